### design/csu_pkg.sv
// Shared types, constants and cursor bitmap tables for the cursor save-under overlay.
package csu_pkg;

   // Cursor geometry
   localparam int unsigned CURSOR_COLS = 12;
   localparam int unsigned CURSOR_ROWS = 18;
   localparam int unsigned CELL_COUNT  = CURSOR_COLS * CURSOR_ROWS;
   localparam int unsigned IDX_W       = $clog2(CELL_COUNT);

   localparam logic [3:0] LAST_COL = 4'd11;
   localparam logic [4:0] LAST_ROW = 5'd17;

   // Field widths
   localparam int unsigned COORD_W  = 13;
   localparam int unsigned STRIDE_W = 14;
   localparam int unsigned ADDR_W   = 25;
   localparam int unsigned PIXEL_W  = 32;

   // Cursor colors
   localparam logic [PIXEL_W-1:0] COLOR_FILL = 32'h00FF_FFFF;
   localparam logic [PIXEL_W-1:0] COLOR_EDGE = 32'h0011_1111;

   // Item kinds carried on tuser
   localparam logic MODE_DRAW  = 1'b0;
   localparam logic MODE_ERASE = 1'b1;

   // Control register indexes
   typedef enum logic [2:0] {
      CSR_CURSOR_X       = 3'd0,
      CSR_CURSOR_Y       = 3'd1,
      CSR_SURFACE_WIDTH  = 3'd2,
      CSR_SURFACE_HEIGHT = 3'd3,
      CSR_SURFACE_STRIDE = 3'd4
   } csr_index_type;

   // Placement result: cell inside the surface and its framebuffer address
   typedef struct packed {
      logic              visible;
      logic [ADDR_W-1:0] addr;
   } place_type;

   // Outline bitmap, bit 11 is the leftmost column
   function automatic logic [11:0] edge_row(input logic [4:0] row);
      logic [11:0] bits;
      case (row)
         5'd0:    bits = 12'h800;
         5'd1:    bits = 12'hC00;
         5'd2:    bits = 12'hE00;
         5'd3:    bits = 12'hF00;
         5'd4:    bits = 12'hF80;
         5'd5:    bits = 12'hFC0;
         5'd6:    bits = 12'hFE0;
         5'd7:    bits = 12'hFF0;
         5'd8:    bits = 12'hFF8;
         5'd9:    bits = 12'hFFC;
         5'd10:   bits = 12'hFFE;
         5'd11:   bits = 12'hFC0;
         5'd12:   bits = 12'hEC0;
         5'd13:   bits = 12'hC60;
         5'd14:   bits = 12'h060;
         5'd15:   bits = 12'h060;
         5'd16:   bits = 12'h030;
         5'd17:   bits = 12'h030;
         default: bits = 12'h000;
      endcase
      return bits;
   endfunction

   // Fill bitmap, bit 11 is the leftmost column
   function automatic logic [11:0] body_row(input logic [4:0] row);
      logic [11:0] bits;
      case (row)
         5'd1:    bits = 12'h400;
         5'd2:    bits = 12'h600;
         5'd3:    bits = 12'h700;
         5'd4:    bits = 12'h780;
         5'd5:    bits = 12'h7C0;
         5'd6:    bits = 12'h7E0;
         5'd7:    bits = 12'h7F0;
         5'd8:    bits = 12'h7F8;
         5'd9:    bits = 12'h7C0;
         5'd10:   bits = 12'h7C0;
         5'd11:   bits = 12'h6C0;
         5'd12:   bits = 12'h440;
         5'd13:   bits = 12'h060;
         5'd14:   bits = 12'h060;
         5'd15:   bits = 12'h020;
         5'd16:   bits = 12'h030;
         default: bits = 12'h000;
      endcase
      return bits;
   endfunction

endpackage

### design/csu_place.sv
// Screen placement of one cursor cell: clip against the surface and form the address.
module csu_place (
   input  logic [csu_pkg::COORD_W-1:0]  origin_x,
   input  logic [csu_pkg::COORD_W-1:0]  origin_y,
   input  logic [3:0]                   cell_col,
   input  logic [4:0]                   cell_row,
   input  logic [csu_pkg::COORD_W-1:0]  surface_width,
   input  logic [csu_pkg::COORD_W-1:0]  surface_height,
   input  logic [csu_pkg::STRIDE_W-1:0] surface_stride,
   output csu_pkg::place_type           place
);
   import csu_pkg::*;

   logic signed [COORD_W:0]        screen_x;
   logic signed [COORD_W:0]        screen_y;
   logic [COORD_W+STRIDE_W-1:0]    row_base;

   // Signed screen position, one bit wider than the origin
   assign screen_x = $signed({origin_x[COORD_W-1], origin_x}) + $signed({10'b0, cell_col});
   assign screen_y = $signed({origin_y[COORD_W-1], origin_y}) + $signed({9'b0, cell_row});

   // Clip: negative or past the surface edge
   assign place.visible = !screen_x[COORD_W] && !screen_y[COORD_W] &&
                          (screen_x[COORD_W-1:0] < surface_width) &&
                          (screen_y[COORD_W-1:0] < surface_height);

   // Address wraps at the address width
   assign row_base   = screen_y[COORD_W-1:0] * surface_stride;
   assign place.addr = row_base[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, screen_x[COORD_W-1:0]};

endmodule

### design/cursor_save_under_overlay.sv
// Cursor overlay with save-under: draws and erases a 12x18 cursor one cell per transaction.
// The block takes one cell transaction every clock while the result side is not
// stalled, and returns exactly one result transaction per cell. A cell goes
// through an input stage, where its save-under entry is read, and a result
// register; clipping, the row*stride+column product and the color pick sit
// between the two. The 216-entry save-under store has one write and one
// registered read per clock, with a same-edge bypass so an erase right behind a
// draw of the same cell sees the fresh value. Reading a cell that was never drawn
// returns an undefined pixel. Control registers must be written only while no cell
// is in flight; the block does not enforce this. The write port is always ready.
module cursor_save_under_overlay (
   input  logic        clock,
   input  logic        reset,
   // Cell input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cell_col[3:0], cell_row[8:4], background_pixel[40:9]
   input  logic        req_tuser,   // mode[0]
   // Result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // write_address[24:0], write_pixel[56:25]
   output logic        rsp_tuser,   // write_enable[0]
   // Control register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);
   import csu_pkg::*;

   // Control registers
   logic [COORD_W-1:0]  cursor_x_ff, cursor_y_ff;
   logic [COORD_W-1:0]  surface_width_ff, surface_height_ff;
   logic [STRIDE_W-1:0] surface_stride_ff;

   // Drawn-cursor state
   logic [COORD_W-1:0]  drawn_x_ff, drawn_y_ff;
   logic                drawn_ff;

   // Input stage
   logic                s1_valid_ff;
   logic                s1_mode_ff;
   logic [3:0]          s1_col_ff;
   logic [4:0]          s1_row_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [PIXEL_W-1:0]  s1_bg_ff;
   logic [PIXEL_W-1:0]  saved_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_we_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [PIXEL_W-1:0]  rsp_pix_ff;

   // Save-under store
   logic [PIXEL_W-1:0]  save_mem [CELL_COUNT];

   logic                req_accept;
   logic                advance;
   logic [3:0]          req_col;
   logic [4:0]          req_row;
   logic                req_in_range;
   logic [IDX_W-1:0]    req_idx;

   logic                in_range;
   logic                is_last;
   logic [3:0]          bit_sel;
   logic [15:0]         edge_bits;
   logic [15:0]         body_bits;
   logic                edge_hit;
   logic                body_hit;
   logic [COORD_W-1:0]  origin_x, origin_y;
   place_type           cell_place;

   logic                store_we;
   logic [PIXEL_W-1:0]  store_wdata;
   logic                drawn_in;
   logic                we_in;
   logic [ADDR_W-1:0]   addr_in;
   logic [PIXEL_W-1:0]  pix_in;

   // Handshakes
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Cell index of the incoming transaction, clamped for cells off the bitmap
   assign req_col      = req_tdata[3:0];
   assign req_row      = req_tdata[8:4];
   assign req_in_range = (req_col <= LAST_COL) && (req_row <= LAST_ROW);
   assign req_idx      = req_in_range ?
                         ({req_row, 3'b000} + {1'b0, req_row, 2'b00} + {4'b0000, req_col}) :
                         '0;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff       <= '0;
         cursor_y_ff       <= '0;
         surface_width_ff  <= 13'd640;
         surface_height_ff <= 13'd480;
         surface_stride_ff <= 14'd640;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CURSOR_X:       cursor_x_ff       <= csr_wdata[COORD_W-1:0];
            CSR_CURSOR_Y:       cursor_y_ff       <= csr_wdata[COORD_W-1:0];
            CSR_SURFACE_WIDTH:  surface_width_ff  <= csr_wdata[COORD_W-1:0];
            CSR_SURFACE_HEIGHT: surface_height_ff <= csr_wdata[COORD_W-1:0];
            CSR_SURFACE_STRIDE: surface_stride_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // Input stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff <= req_tuser;
         s1_col_ff  <= req_col;
         s1_row_ff  <= req_row;
         s1_idx_ff  <= req_idx;
         s1_bg_ff   <= req_tdata[40:9];
      end
   end

   // Save-under store: write from the input stage, read on accept with bypass
   always_ff @(posedge clock) begin
      if (store_we) begin
         save_mem[s1_idx_ff] <= store_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (store_we && (s1_idx_ff == req_idx)) begin
            saved_ff <= store_wdata;
         end else begin
            saved_ff <= save_mem[req_idx];
         end
      end
   end

   // Bitmap lookup for the cell in the input stage
   assign in_range  = (s1_col_ff <= LAST_COL) && (s1_row_ff <= LAST_ROW);
   assign is_last   = (s1_col_ff == LAST_COL) && (s1_row_ff == LAST_ROW);
   assign bit_sel   = LAST_COL - s1_col_ff;
   assign edge_bits = {4'b0000, edge_row(s1_row_ff)};
   assign body_bits = {4'b0000, body_row(s1_row_ff)};
   assign edge_hit  = in_range && edge_bits[bit_sel];
   assign body_hit  = body_bits[bit_sel];

   // Draw places at the live cursor, erase at the drawn one
   assign origin_x = (s1_mode_ff == MODE_DRAW) ? cursor_x_ff : drawn_x_ff;
   assign origin_y = (s1_mode_ff == MODE_DRAW) ? cursor_y_ff : drawn_y_ff;

   csu_place u_place (
      .origin_x       (origin_x),
      .origin_y       (origin_y),
      .cell_col       (s1_col_ff),
      .cell_row       (s1_row_ff),
      .surface_width  (surface_width_ff),
      .surface_height (surface_height_ff),
      .surface_stride (surface_stride_ff),
      .place          (cell_place)
   );

   // Cell result and state updates
   always_comb begin
      store_we    = advance && in_range && (s1_mode_ff == MODE_DRAW);
      store_wdata = cell_place.visible ? s1_bg_ff : '0;
      drawn_in    = drawn_ff;
      we_in       = 1'b0;
      pix_in      = '0;
      if (advance && in_range && is_last) begin
         if (s1_mode_ff == MODE_DRAW) begin
            drawn_in = 1'b1;
         end else begin
            drawn_in = 1'b0;
         end
      end
      if (s1_mode_ff == MODE_DRAW) begin
         we_in  = edge_hit && cell_place.visible;
         pix_in = body_hit ? COLOR_FILL : COLOR_EDGE;
      end else begin
         we_in  = edge_hit && drawn_ff && cell_place.visible;
         pix_in = saved_ff;
      end
      addr_in = we_in ? cell_place.addr : '0;
      if (!we_in) begin
         pix_in = '0;
      end
   end

   // Drawn-cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         drawn_ff   <= 1'b0;
         drawn_x_ff <= '0;
         drawn_y_ff <= '0;
      end else begin
         drawn_ff <= drawn_in;
         if (store_we && is_last) begin
            drawn_x_ff <= cursor_x_ff;
            drawn_y_ff <= cursor_y_ff;
         end
      end
   end

   // Result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_we_ff   <= we_in;
         rsp_addr_ff <= addr_in;
         rsp_pix_ff  <= pix_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = {7'b0000000, rsp_pix_ff, rsp_addr_ff};

   // The drawn flag only sets when the last draw cell leaves the input stage
   a_drawn_set: assert property (@(posedge clock) disable iff (reset)
      $rose(drawn_ff) |-> $past(advance && (s1_mode_ff == MODE_DRAW) && is_last))
      else $error("drawn flag set without a last draw cell");

   // An accepted cell lands in the input stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted cell lost at the input stage");

   // A stalled input stage holds its cell
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_idx_ff) && $stable(s1_mode_ff)))
      else $error("input stage changed while stalled");

   // Erase while the cursor is not drawn never writes
   a_erase_undrawn: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_mode_ff == MODE_ERASE) && !drawn_ff) |=> !rsp_we_ff)
      else $error("erase wrote while cursor not drawn");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the cursor save-under overlay, directed and randomized.
module tb_top;
   import csu_pkg::*;

   // One framebuffer write as seen on the result stream
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [PIXEL_W-1:0] wr_pixel;
   } fb_write_type;

   // Cursor bitmaps, row r in bits [r*12 +: 12], bit 11 of a row is the leftmost column
   localparam logic [CELL_COUNT-1:0] OUTLINE_MAP = {
      12'h030, 12'h030, 12'h060, 12'h060, 12'hC60, 12'hEC0, 12'hFC0, 12'hFFE, 12'hFFC,
      12'hFF8, 12'hFF0, 12'hFE0, 12'hFC0, 12'hF80, 12'hF00, 12'hE00, 12'hC00, 12'h800};
   localparam logic [CELL_COUNT-1:0] SOLID_MAP = {
      12'h000, 12'h030, 12'h020, 12'h060, 12'h060, 12'h440, 12'h6C0, 12'h7C0, 12'h7C0,
      12'h7F8, 12'h7F0, 12'h7E0, 12'h7C0, 12'h780, 12'h700, 12'h600, 12'h400, 12'h000};

   localparam int RANDOM_CELLS = 1350;
   localparam int DRAIN_LIMIT  = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = MODE_DRAW;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_CURSOR_X;
   logic [13:0] csr_wdata = '0;

   // Mirror of the block's registers and save-under state
   logic [12:0] reg_cursor_x = '0;
   logic [12:0] reg_cursor_y = '0;
   logic [12:0] reg_width    = 13'd640;
   logic [12:0] reg_height   = 13'd480;
   logic [13:0] reg_stride   = 14'd640;
   logic [PIXEL_W-1:0] under_pixel [CELL_COUNT];
   bit          under_valid [CELL_COUNT];
   logic [12:0] shown_x = '0;
   logic [12:0] shown_y = '0;
   bit          shown = 1'b0;

   fb_write_type expected_writes [$];
   int          fail_count = 0;
   int          cells_sent = 0;
   int          hold_request = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;

   cursor_save_under_overlay u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Hard stop in case the handshakes hang
   initial begin
      #4_000_000;
      $display("[cursor_save_under_overlay] ERROR");
      $finish;
   end

   function automatic void flag_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   // Clip a cell against the surface and form row*stride+column
   function automatic bit screen_addr(input logic [12:0] ox, input logic [12:0] oy,
                                      input logic [3:0] col, input logic [4:0] row,
                                      output logic [ADDR_W-1:0] addr);
      int sx, sy;
      longint unsigned lin;
      addr = '0;
      sx = {{19{ox[12]}}, ox};
      sy = {{19{oy[12]}}, oy};
      sx = sx + int'(col);
      sy = sy + int'(row);
      if (sx < 0 || sy < 0) return 1'b0;
      if (sx >= int'(reg_width) || sy >= int'(reg_height)) return 1'b0;
      lin = longint'(sy) * reg_stride + longint'(sx);
      addr = lin[ADDR_W-1:0];
      return 1'b1;
   endfunction

   // Expected write for one accepted cell; updates the mirrored state
   function automatic fb_write_type cursor_cell_write(input logic mode, input logic [3:0] col,
                                                      input logic [4:0] row,
                                                      input logic [PIXEL_W-1:0] bg);
      fb_write_type w;
      int idx, bitpos;
      bit outline, last_cell, vis;
      logic [ADDR_W-1:0] a;
      w = '0;
      if (col < CURSOR_COLS && row < CURSOR_ROWS) begin
         idx = row * CURSOR_COLS + col;
         bitpos = row * 12 + 11 - col;
         outline = OUTLINE_MAP[bitpos];
         last_cell = (row == LAST_ROW) && (col == LAST_COL);
         if (mode == MODE_DRAW) begin
            vis = screen_addr(reg_cursor_x, reg_cursor_y, col, row, a);
            under_pixel[idx] = vis ? bg : '0;
            under_valid[idx] = 1'b1;
            if (vis && outline) begin
               w.wr_en = 1'b1;
               w.wr_addr = a;
               w.wr_pixel = SOLID_MAP[bitpos] ? COLOR_FILL : COLOR_EDGE;
            end
            if (last_cell) begin
               shown_x = reg_cursor_x;
               shown_y = reg_cursor_y;
               shown = 1'b1;
            end
         end else if (shown) begin
            vis = screen_addr(shown_x, shown_y, col, row, a);
            if (outline && vis) begin
               w.wr_en = 1'b1;
               w.wr_addr = a;
               w.wr_pixel = under_pixel[idx];
            end
            if (last_cell) shown = 1'b0;
         end
      end
      return w;
   endfunction

   // True when an erase of this cell would restore a save-under entry never filled
   function automatic bit reads_unsaved(input logic [3:0] col, input logic [4:0] row);
      logic [ADDR_W-1:0] a;
      int idx;
      if (!shown || col >= CURSOR_COLS || row >= CURSOR_ROWS) return 1'b0;
      idx = row * CURSOR_COLS + col;
      if (!OUTLINE_MAP[row * 12 + 11 - col]) return 1'b0;
      return screen_addr(shown_x, shown_y, col, row, a) && !under_valid[idx];
   endfunction

   // Offer one cell transaction; called and returns at a rising edge
   task automatic send_cell(input logic mode, input logic [3:0] col, input logic [4:0] row,
                            input logic [PIXEL_W-1:0] bg);
      int gap;
      fb_write_type w;
      gap = tx_quiet ? 0 : $urandom_range(0, 10);
      if (mode == MODE_ERASE && reads_unsaved(col, row)) mode = MODE_DRAW;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, bg, row, col};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      w = cursor_cell_write(mode, col, row, bg);
      expected_writes.push_back(w);
      if (col < CURSOR_COLS && row < CURSOR_ROWS) cells_sent++;
   endtask

   task automatic send_noise();
      send_cell(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                5'($urandom_range(0, 31)), $urandom());
   endtask

   // Stop offering cells and let every outstanding write come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Rewrite all five control registers once the block is idle
   task automatic program_regs(input logic [12:0] cx, input logic [12:0] cy,
                               input logic [12:0] w, input logic [12:0] h,
                               input logic [13:0] stride);
      csr_index_type idx;
      logic [13:0] val;
      int i;
      wait_idle();
      for (i = 0; i < 5; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_CURSOR_X:       val = {1'b0, cx};
            CSR_CURSOR_Y:       val = {1'b0, cy};
            CSR_SURFACE_WIDTH:  val = {1'b0, w};
            CSR_SURFACE_HEIGHT: val = {1'b0, h};
            default:            val = stride;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         @(negedge clock);
         while (!csr_ready) @(negedge clock);
         @(posedge clock);
         case (idx)
            CSR_CURSOR_X:       reg_cursor_x = val[12:0];
            CSR_CURSOR_Y:       reg_cursor_y = val[12:0];
            CSR_SURFACE_WIDTH:  reg_width    = val[12:0];
            CSR_SURFACE_HEIGHT: reg_height   = val[12:0];
            default:            reg_stride   = val;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Row-major pass over the first count cells, optionally repeating each cell in the other mode right after it
   task automatic sweep_cells(input logic mode, input bit interleave, input int count);
      int n;
      for (n = 0; n < count; n++) begin
         send_cell(mode, 4'(n % CURSOR_COLS), 5'(n / CURSOR_COLS), $urandom());
         if (interleave) send_cell(~mode, 4'(n % CURSOR_COLS), 5'(n / CURSOR_COLS), $urandom());
         if ($urandom_range(0, 23) == 0) send_noise();
      end
   endtask

   // Cells in random order and mode, mostly inside the bitmap
   task automatic scatter_cells(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_cell(1'($urandom_range(0, 1)), 4'($urandom_range(0, 11)),
                        5'($urandom_range(0, 17)), $urandom());
      end
   endtask

   function automatic logic [12:0] pick_extent();
      case ($urandom_range(0, 7))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'h1FFF;
         4:       return 13'($urandom_range(1, 64));
         default: return 13'($urandom_range(200, 4096));
      endcase
   endfunction

   function automatic logic [13:0] pick_stride(input logic [12:0] w);
      case ($urandom_range(0, 5))
         0:       return 14'd0;
         1:       return 14'h3FFF;
         2:       return 14'd1;
         3:       return {1'b0, w};
         default: return 14'($urandom_range(1, 8192));
      endcase
   endfunction

   // Cursor origin: extremes, anywhere, or straddling the surface border
   function automatic logic [12:0] pick_origin(input logic [12:0] extent);
      int v;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 13'h1000;
               1:       return 13'h0FFF;
               2:       return 13'h1FFF;
               3:       return 13'h1800;
               default: return 13'h0000;
            endcase
         end
         1: return 13'($urandom_range(0, 8191));
         default: begin
            v = $urandom_range(0, int'(extent) + 24);
            v = v - 16;
            return v[12:0];
         end
      endcase
   endfunction

   // Move the cursor, and now and then change the surface too
   task automatic randomize_layout();
      logic [12:0] w, h;
      logic [13:0] s;
      w = reg_width;
      h = reg_height;
      s = reg_stride;
      if ($urandom_range(0, 2) == 0) begin
         w = pick_extent();
         h = pick_extent();
         s = pick_stride(w);
      end
      program_regs(pick_origin(w), pick_origin(h), w, h, s);
   endtask

   // Result side: random stalls, quiet stretches and requested long hold-offs
   initial begin : rsp_drain
      int stall;
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = rx_quiet ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
      end
   end

   // Compare each result transaction with the oldest expected write
   always @(negedge clock) begin : result_check
      fb_write_type want;
      logic [ADDR_W-1:0] got_addr;
      logic [PIXEL_W-1:0] got_pixel;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_addr  = rsp_tdata[24:0];
         got_pixel = rsp_tdata[56:25];
         if (expected_writes.size() == 0) begin
            flag_error($sformatf("unexpected write: en=%0b addr=%h pixel=%h",
                                 rsp_tuser, got_addr, got_pixel));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_tuser !== want.wr_en || got_addr !== want.wr_addr ||
                got_pixel !== want.wr_pixel)
               flag_error($sformatf(
                  "write mismatch: exp en=%0b addr=%h pixel=%h, got en=%0b addr=%h pixel=%h",
                  want.wr_en, want.wr_addr, want.wr_pixel,
                  rsp_tuser, got_addr, got_pixel));
         end
      end
   end

   // Erase before anything is drawn: no writes, flag stays clear
   task automatic test_erase_while_hidden();
      send_cell(MODE_ERASE, 4'd0, 5'd0, 32'hFFFF_FFFF);
      send_cell(MODE_ERASE, LAST_COL, LAST_ROW, 32'h0000_0000);
   endtask

   // Cells outside the 12x18 bitmap are ignored in both modes
   task automatic test_cells_outside_bitmap();
      send_cell(MODE_DRAW, 4'd12, 5'd0, 32'hFFFF_FFFF);
      send_cell(MODE_DRAW, 4'd15, 5'd31, 32'hFFFF_FFFF);
      send_cell(MODE_ERASE, 4'd0, 5'd18, 32'h0000_0000);
      send_cell(MODE_ERASE, 4'd11, 5'd31, 32'hA5A5_A5A5);
   endtask

   // Draw outline and fill cells plus the last cell, then restore them
   task automatic test_draw_then_restore();
      send_cell(MODE_DRAW, 4'd0, 5'd0, 32'h0000_0000);
      send_cell(MODE_DRAW, 4'd11, 5'd0, 32'hFFFF_FFFF);
      send_cell(MODE_DRAW, 4'd1, 5'd1, 32'hAAAA_AAAA);
      send_cell(MODE_DRAW, 4'd0, 5'd1, 32'h5555_5555);
      send_cell(MODE_DRAW, LAST_COL, LAST_ROW, 32'hFFFF_FFFF);
      send_cell(MODE_ERASE, 4'd0, 5'd0, 32'h1234_5678);
      send_cell(MODE_ERASE, 4'd1, 5'd1, 32'h0);
      send_cell(MODE_ERASE, 4'd0, 5'd1, 32'h0);
      send_cell(MODE_ERASE, LAST_COL, LAST_ROW, 32'h0);
   endtask

   // Zero stride, address wrap, zero width and height, negative origins
   task automatic test_surface_edges();
      program_regs(13'd100, 13'd200, 13'd640, 13'd480, 14'd0);
      send_cell(MODE_DRAW, 4'd3, 5'd10, 32'h1234_5678);
      program_regs(13'h0FFF, 13'h0FFF, 13'h1FFF, 13'h1FFF, 14'h3FFF);
      send_cell(MODE_DRAW, 4'd0, 5'd0, 32'hFFFF_FFFF);
      send_cell(MODE_DRAW, 4'd6, 5'd16, 32'hFFFF_FFFF);
      program_regs(13'd0, 13'd0, 13'd0, 13'd480, 14'd640);
      send_cell(MODE_DRAW, 4'd0, 5'd5, 32'hDEAD_BEEF);
      program_regs(13'h1000, 13'h1FFF, 13'd640, 13'd0, 14'd640);
      send_cell(MODE_DRAW, 4'd11, 5'd10, 32'hCAFE_F00D);
      program_regs(13'h1FFE, 13'h1FFF, 13'd640, 13'd480, 14'd640);
      send_cell(MODE_DRAW, 4'd2, 5'd3, 32'h0F0F_0F0F);
   endtask

   // Long result hold-off while cells keep coming back to back
   task automatic test_backpressure();
      program_regs(13'd20, 13'd30, 13'd640, 13'd480, 14'd640);
      tx_quiet = 1'b1;
      hold_request = 150;
      sweep_cells(MODE_DRAW, 1'b0, 60);
      tx_quiet = 1'b0;
   endtask

   // Mostly full draw and erase sweeps with random pixels, plus broken sweeps and noise
   task automatic test_random_traffic();
      int goal;
      program_regs(13'd300, 13'd200, 13'd640, 13'd480, 14'd640);
      goal = cells_sent + RANDOM_CELLS;
      while (cells_sent < goal) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) != 0) randomize_layout();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: sweep_cells(MODE_DRAW, 1'b0, CELL_COUNT);
            4, 5, 6:    sweep_cells(MODE_ERASE, 1'b0, CELL_COUNT);
            7:          sweep_cells(MODE_DRAW, 1'b1, CELL_COUNT);
            8:          sweep_cells(1'($urandom_range(0, 1)), 1'b0,
                                    $urandom_range(1, CELL_COUNT - 1));
            default:    scatter_cells(40);
         endcase
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin : stimulus
      int guard;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_erase_while_hidden();
      test_cells_outside_bitmap();
      test_draw_then_restore();
      test_surface_edges();
      test_backpressure();
      test_random_traffic();
      // Drain, then allow for any stray result transactions
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_writes.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (expected_writes.size() != 0)
         flag_error($sformatf("%0d expected writes never arrived", expected_writes.size()));
      if (fail_count == 0)
         $display("[cursor_save_under_overlay] OK");
      else
         $display("[cursor_save_under_overlay] ERROR");
      $finish;
   end

endmodule
